FILE: design/fpfa_pkg.sv
// Shared constants, codes and types of the fixed-partition fit allocator.
// No dependencies; every other design file refers to this package.
package fpfa_pkg;

	localparam int MAX_BLOCKS = 16;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);

	// Fixed field widths
	localparam int OP_W       = 2;
	localparam int BIDX_W     = 4;
	localparam int SIZE_W     = 32;
	localparam int GB_W       = 4;
	localparam int MODE_W     = 2;
	localparam int NB_W       = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;
	localparam int CMP_W      = (IDX_W > NB_W) ? IDX_W : NB_W;

	// Request op codes (code 3 is ignored)
	localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd2;

	// Fit modes (code 3 acts as first fit)
	localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
	localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIT_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_BLOCKS = 2'd1;

	// Search token passed from cell to cell
	typedef struct packed {
		logic              valid;
		logic              found;
		logic [IDX_W-1:0]  best_idx;
		logic [SIZE_W-1:0] best_size;
		logic [SIZE_W-1:0] req_size;
	} tok_t;

	// Broadcast commands to all cells
	typedef struct packed {
		logic              load;
		logic              clear;
		logic              grant;
		logic [IDX_W-1:0]  idx;
		logic [SIZE_W-1:0] data;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_HOLD
	} state_t;

endpackage

FILE: design/fpfa_req_if.sv
// Request channel of the allocator: valid/ready plus op, block index and size.
// Depends on fpfa_pkg.
interface fpfa_req_if;
	logic                        valid;
	logic                        ready;
	logic [fpfa_pkg::OP_W-1:0]   op;
	logic [fpfa_pkg::BIDX_W-1:0] block_index;
	logic [fpfa_pkg::SIZE_W-1:0] size;

	modport source (output valid, op, block_index, size, input ready);
	modport sink (input valid, op, block_index, size, output ready);
endinterface

FILE: design/fpfa_rsp_if.sv
// Response channel of the allocator: valid/ready plus grant flag and block index.
// Depends on fpfa_pkg.
interface fpfa_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      granted;
	logic [fpfa_pkg::GB_W-1:0] granted_block;

	modport source (output valid, granted, granted_block, input ready);
	modport sink (input valid, granted, granted_block, output ready);
endinterface

FILE: design/fpfa_cfg_if.sv
// Configuration write channel: valid/ready plus register index and write data.
// Depends on fpfa_pkg.
interface fpfa_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fpfa_pkg::CFG_IDX_W-1:0]  index;
	logic [fpfa_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: design/fpfa_cell.sv
// One block cell: holds a block size and its used mark, and refines the search
// token on its way to the next cell. Depends on fpfa_pkg.
module fpfa_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [fpfa_pkg::IDX_W-1:0]    cell_idx,
	input  logic [fpfa_pkg::MODE_W-1:0]   fit_mode,
	input  logic [fpfa_pkg::NB_W-1:0]     num_blocks,
	input  fpfa_pkg::cmd_t                cmd,
	input  fpfa_pkg::tok_t                tok_in,
	output fpfa_pkg::tok_t                tok_out,
	output logic                          used
);

	logic [fpfa_pkg::SIZE_W-1:0] size_q;
	logic                        used_q;
	logic                        valid_q;
	fpfa_pkg::tok_t              pay_q;
	fpfa_pkg::tok_t              tok_next;
	logic                        hit;
	logic                        active;
	logic                        fits;
	logic                        better;

	assign hit    = (cmd.idx == cell_idx);
	assign active = fpfa_pkg::CMP_W'(cell_idx) < fpfa_pkg::CMP_W'(num_blocks);
	assign fits   = active && !used_q && (size_q >= tok_in.req_size);

	always_comb begin
		case (fit_mode)
			fpfa_pkg::MODE_BEST:  better = !tok_in.found || (size_q < tok_in.best_size);
			fpfa_pkg::MODE_WORST: better = !tok_in.found || (size_q > tok_in.best_size);
			default:              better = !tok_in.found;
		endcase
	end

	always_comb begin
		tok_next = tok_in;
		if (fits && better) begin
			tok_next.found     = 1'b1;
			tok_next.best_idx  = cell_idx;
			tok_next.best_size = size_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load && hit) begin
			size_q <= cmd.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (cmd.clear) begin
			used_q <= 1'b0;
		end else if (cmd.grant && hit) begin
			used_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tok_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tok_in.valid) begin
			pay_q <= tok_next;
		end
	end

	always_comb begin
		tok_out       = pay_q;
		tok_out.valid = valid_q;
	end

	assign used = used_q;

endmodule

FILE: design/fixed_partition_fit_allocator.sv
// Top level of the fixed-partition fit allocator: a row of block cells and the
// request, response and configuration channels. Depends on fpfa_pkg, fpfa_cell
// and the three channel interfaces.
//
// Usage
//   req  : one request per handshake. Load writes a block size, clear frees
//          every block, allocate searches for a block. Op code 3 is dropped.
//   rsp  : one response per allocate: granted flag and block index (0 when
//          nothing fits). Load and clear give no response.
//   cfg  : register 0 is the fit mode (first, best, worst), register 1 the
//          number of blocks in use. Always ready; write only while idle.
// Timing
//   Load and clear keep req.ready high, so the next request can follow at once.
//   An allocate sends a search token down the row of cells, one cell per
//   cycle; req.ready stays low while the search runs and until the result
//   leaves the holding register, and it rises again the cycle the response
//   appears. A new allocate is taken only after the response of the last one
//   has gone into the output register.
// Reset clears fit mode, block count, all used marks and the handshake state.
// Block sizes are not reset: load every block in use before allocating.
// If rsp is stalled, the response waits in the output register and new
// requests are still taken; a second allocate finishes its search and then
// waits in a holding register until the first response is taken.
module fixed_partition_fit_allocator (
	input  logic       clk,
	input  logic       arst_n,
	fpfa_req_if.sink   req,
	fpfa_rsp_if.source rsp,
	fpfa_cfg_if.sink   cfg
);

	localparam int N = fpfa_pkg::MAX_BLOCKS;

	fpfa_pkg::state_t                state_q;
	fpfa_pkg::state_t                state_next;
	logic [fpfa_pkg::MODE_W-1:0]     fit_mode_q;
	logic [fpfa_pkg::NB_W-1:0]       num_blocks_q;

	// Token injection into the first cell
	logic                            inj_valid_q;
	logic [fpfa_pkg::SIZE_W-1:0]     inj_req_q;

	// Finished search waiting for the output register
	logic                            hold_found_q;
	logic [fpfa_pkg::IDX_W-1:0]      hold_idx_q;

	logic                            rsp_valid_q;
	logic                            rsp_granted_q;
	logic [fpfa_pkg::GB_W-1:0]       rsp_block_q;

	fpfa_pkg::tok_t                  chain [N+1];
	logic [N:0]                      tok_vld;
	logic [N-1:0]                    used_vec;
	fpfa_pkg::cmd_t                  cmd;
	fpfa_pkg::tok_t                  tail;

	logic req_acc;
	logic alloc_acc;
	logic in_rdy;
	logic capture;
	logic push;
	logic slot_free;

	// Handshakes
	assign req_acc   = req.valid && in_rdy;
	assign alloc_acc = req_acc && (req.op == fpfa_pkg::OP_ALLOC);
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign tail      = chain[N];

	// Next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			fpfa_pkg::ST_IDLE: if (alloc_acc) state_next = fpfa_pkg::ST_SCAN;
			fpfa_pkg::ST_SCAN: if (tail.valid) state_next = fpfa_pkg::ST_HOLD;
			fpfa_pkg::ST_HOLD: if (slot_free) state_next = fpfa_pkg::ST_IDLE;
			default:           state_next = fpfa_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_rdy  = 1'b0;
		capture = 1'b0;
		push    = 1'b0;
		case (state_q)
			fpfa_pkg::ST_IDLE: in_rdy = 1'b1;
			fpfa_pkg::ST_SCAN: capture = tail.valid;
			fpfa_pkg::ST_HOLD: push = slot_free;
			default:           in_rdy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpfa_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_mode_q   <= fpfa_pkg::MODE_FIRST;
			num_blocks_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				fpfa_pkg::REG_FIT_MODE:   fit_mode_q <= cfg.data[fpfa_pkg::MODE_W-1:0];
				fpfa_pkg::REG_NUM_BLOCKS: num_blocks_q <= cfg.data[fpfa_pkg::NB_W-1:0];
				default:                  ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// Broadcast commands: load and clear straight from the request, grant
	// when the search token leaves the last cell with a winner.
	always_comb begin
		cmd       = '0;
		cmd.load  = req_acc && (req.op == fpfa_pkg::OP_LOAD)
			&& (int'(req.block_index) < N);
		cmd.clear = req_acc && (req.op == fpfa_pkg::OP_CLEAR);
		cmd.data  = req.size;
		if (capture) begin
			cmd.grant = tail.found;
			cmd.idx   = tail.best_idx;
		end else begin
			cmd.idx   = fpfa_pkg::IDX_W'(req.block_index);
		end
	end

	// Token injection
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inj_valid_q <= 1'b0;
		end else begin
			inj_valid_q <= alloc_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (alloc_acc) begin
			inj_req_q <= req.size;
		end
	end

	always_comb begin
		chain[0]          = '0;
		chain[0].valid    = inj_valid_q;
		chain[0].req_size = inj_req_q;
	end

	// Row of cells
	for (genvar k = 0; k < N; k++) begin : g_cell
		fpfa_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cell_idx   (fpfa_pkg::IDX_W'(k)),
			.fit_mode   (fit_mode_q),
			.num_blocks (num_blocks_q),
			.cmd        (cmd),
			.tok_in     (chain[k]),
			.tok_out    (chain[k+1]),
			.used       (used_vec[k])
		);
	end

	for (genvar k = 0; k <= N; k++) begin : g_vld
		assign tok_vld[k] = chain[k].valid;
	end

	// Holding register for a finished search
	always_ff @(posedge clk) begin
		if (capture) begin
			hold_found_q <= tail.found;
			hold_idx_q   <= tail.best_idx;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (push) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			rsp_granted_q <= hold_found_q;
			rsp_block_q   <= hold_found_q ? fpfa_pkg::GB_W'(hold_idx_q) : '0;
		end
	end

	assign req.ready         = in_rdy;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.granted       = rsp_granted_q;
	assign rsp.granted_block = rsp_block_q;

	// At most one search token in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("more than one search token in flight");

	// A grant never lands on a block already in use
	a_grant_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.grant |-> !used_vec[cmd.idx])
		else $error("grant to a used block");

	// The token leaves the row only while a search is running
	a_tail_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tail.valid |-> (state_q == fpfa_pkg::ST_SCAN))
		else $error("search token outside a search");

	// A refusal reports block zero
	a_refuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.granted) |-> (rsp.granted_block == '0))
		else $error("refusal with nonzero block");

endmodule

FILE: verif/fixed_partition_fit_allocator_test.sv
// Self-checking testbench for fixed_partition_fit_allocator: a directed request
// table, then random rounds over fit modes and block counts, checked by a predictor.
// Depends on fpfa_pkg, the three channel interfaces and the allocator top level.
`timescale 1ns / 1ps

module fixed_partition_fit_allocator_test;

	localparam int CLK_PERIOD    = 4;
	localparam int RANDOM_ITEMS  = 1826;
	// Quiet time after the owed grants: longer than an allocate search, with margin
	localparam int SETTLE_CYCLES = fpfa_pkg::MAX_BLOCKS + 8;
	localparam int CYCLE_LIMIT   = 1000000;

	// Codes the package leaves unnamed: dropped op, mode that acts as first fit
	localparam logic [fpfa_pkg::OP_W-1:0]   OP_UNUSED   = 2'd3;
	localparam logic [fpfa_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic                      granted;
		logic [fpfa_pkg::GB_W-1:0] granted_block;
	} grant_t;

	localparam grant_t NO_GRANT = '{1'b0, 4'd0};

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	// One directed step: a request (code = op) or a register write (code = index)
	typedef struct packed {
		row_kind_t                   kind;
		logic [1:0]                  code;
		logic [fpfa_pkg::BIDX_W-1:0] idx;
		logic [fpfa_pkg::SIZE_W-1:0] value;
		logic                        typed;
		grant_t                      want;
	} row_t;

	localparam int SCRIPT_LEN = 28;

	// Blocks 0..3 end up as max, 0, 100/10, 50/10. Rows with typed = 1 carry a
	// hand-worked grant; the rest (ties, best/worst picks) go to the predictor.
	localparam row_t SCRIPT [SCRIPT_LEN] = '{
		// count is 0 after reset: nothing can be granted
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd0,         1'b1, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_LOAD,  4'd0,  32'hFFFF_FFFF, 1'b0, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_LOAD,  4'd1,  32'd0,         1'b0, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_LOAD,  4'd2,  32'd100,       1'b0, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_LOAD,  4'd3,  32'd50,        1'b0, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_LOAD,  4'd15, 32'h5A5A_A5A5, 1'b0, NO_GRANT},
		// dropped op: no response
		'{ROW_REQ, OP_UNUSED,          4'd15, 32'hFFFF_FFFF, 1'b0, NO_GRANT},
		'{ROW_CFG, fpfa_pkg::REG_NUM_BLOCKS, 4'd0, 32'd4,    1'b0, NO_GRANT},
		// first fit
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd60,        1'b1, '{1'b1, 4'd0}},
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd60,        1'b1, '{1'b1, 4'd2}},
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd60,        1'b1, NO_GRANT},
		// zero-size request fits the zero-size block
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd0,         1'b1, '{1'b1, 4'd1}},
		// reload of a used block keeps it used
		'{ROW_REQ, fpfa_pkg::OP_LOAD,  4'd2,  32'd10,        1'b0, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd0,         1'b1, '{1'b1, 4'd3}},
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd0,         1'b1, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_CLEAR, 4'd9,  32'd0,         1'b0, NO_GRANT},
		'{ROW_CFG, fpfa_pkg::REG_FIT_MODE, 4'd0, 32'(fpfa_pkg::MODE_BEST), 1'b0, NO_GRANT},
		// blocks 2 and 3 tie at 10
		'{ROW_REQ, fpfa_pkg::OP_LOAD,  4'd3,  32'd10,        1'b0, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd5,         1'b0, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd5,         1'b0, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd5,         1'b0, NO_GRANT},
		'{ROW_CFG, fpfa_pkg::REG_FIT_MODE, 4'd0, 32'(fpfa_pkg::MODE_WORST), 1'b0, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_CLEAR, 4'd0,  32'hFFFF_FFFF, 1'b0, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd0,         1'b0, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd1,         1'b0, NO_GRANT},
		'{ROW_CFG, fpfa_pkg::REG_FIT_MODE, 4'd0, 32'(MODE_UNUSED), 1'b0, NO_GRANT},
		// largest request against the free small blocks: miss
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'hFFFF_FFFF, 1'b1, NO_GRANT},
		'{ROW_REQ, fpfa_pkg::OP_ALLOC, 4'd0,  32'd0,         1'b0, NO_GRANT}
	};

	logic clk = 1'b0;
	logic arst_n;

	fpfa_req_if req_ch();
	fpfa_rsp_if rsp_ch();
	fpfa_cfg_if cfg_ch();

	fixed_partition_fit_allocator dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Predictor state: table contents, used marks, which entries were loaded,
	// and the two registers as last written
	logic [fpfa_pkg::SIZE_W-1:0] blk_size   [fpfa_pkg::MAX_BLOCKS];
	logic                        blk_used   [fpfa_pkg::MAX_BLOCKS];
	logic                        blk_loaded [fpfa_pkg::MAX_BLOCKS];
	logic [fpfa_pkg::MODE_W-1:0] fit_mode;
	logic [fpfa_pkg::NB_W-1:0]   block_count;

	grant_t      grant_q [$];   // grants still owed by the block, oldest first
	int          errors = 0;
	int unsigned cycle_count = 0;
	int          burst_left = 0;
	bit          gaps_on = 1'b1;

	// Count above the table size acts as the whole table
	function automatic int active_span();
		return (block_count > fpfa_pkg::MAX_BLOCKS) ? fpfa_pkg::MAX_BLOCKS
			: int'(block_count);
	endfunction

	// Fit search over the free blocks in use; ties keep the lowest index
	function automatic grant_t allocate_block(logic [fpfa_pkg::SIZE_W-1:0] request);
		int     pick;
		grant_t g;
		pick = -1;
		for (int k = 0; k < active_span(); k++) begin
			if (!blk_used[k] && blk_size[k] >= request) begin
				if (pick < 0)
					pick = k;
				else if (fit_mode == fpfa_pkg::MODE_BEST && blk_size[k] < blk_size[pick])
					pick = k;
				else if (fit_mode == fpfa_pkg::MODE_WORST && blk_size[k] > blk_size[pick])
					pick = k;
			end
		end
		if (pick >= 0) begin
			blk_used[pick] = 1'b1;
			g = '{1'b1, fpfa_pkg::GB_W'(pick)};
		end else begin
			g = NO_GRANT;
		end
		return g;
	endfunction

	// Mostly small sizes so that fits and ties are common, plus the extremes
	function automatic logic [fpfa_pkg::SIZE_W-1:0] random_size();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return $urandom();
			3: return 32'hFFFF_FFF0 | $urandom_range(0, 15);
			4, 5: return $urandom_range(0, 1000);
			default: return $urandom_range(0, 15);
		endcase
	endfunction

	// Drive one request, wait for the handshake, then update the predictor.
	// Valid stays high after acceptance so back-to-back requests need no toggle.
	task automatic send_request(logic [fpfa_pkg::OP_W-1:0] op,
			logic [fpfa_pkg::BIDX_W-1:0] idx, logic [fpfa_pkg::SIZE_W-1:0] size,
			logic typed, grant_t want);
		grant_t got;
		if (gaps_on && burst_left == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = $urandom_range(1, 10);
		end
		if (burst_left > 0)
			burst_left--;
		req_ch.valid       <= 1'b1;
		req_ch.op          <= op;
		req_ch.block_index <= idx;
		req_ch.size        <= size;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		case (op)
			fpfa_pkg::OP_LOAD: begin
				blk_size[idx]   = size;
				blk_loaded[idx] = 1'b1;
			end
			fpfa_pkg::OP_CLEAR: foreach (blk_used[b]) blk_used[b] = 1'b0;
			fpfa_pkg::OP_ALLOC: begin
				got = allocate_block(size);
				grant_q.push_back(typed ? want : got);
			end
			default: ;
		endcase
	endtask

	// Stop requesting, let every owed grant arrive, then let the block go quiet
	task automatic hold_requests();
		req_ch.valid <= 1'b0;
		while (grant_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register writes only happen with the block idle
	task automatic write_reg(logic [fpfa_pkg::CFG_IDX_W-1:0] index,
			logic [fpfa_pkg::CFG_DATA_W-1:0] data);
		hold_requests();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		if (index == fpfa_pkg::REG_FIT_MODE)
			fit_mode = data[fpfa_pkg::MODE_W-1:0];
		else if (index == fpfa_pkg::REG_NUM_BLOCKS)
			block_count = data[fpfa_pkg::NB_W-1:0];
	endtask

	// Cycle count doubles as the run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("fixed_partition_fit_allocator test failed");
			$finish;
		end
	end

	// Response stalls: free-running, random, periodic, long stalls
	always @(posedge clk) begin
		case (cycle_count[9:8])
			2'd0: rsp_ch.ready <= 1'b1;
			2'd1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
			2'd2: rsp_ch.ready <= (cycle_count % 3 == 0);
			default: rsp_ch.ready <= (cycle_count[4:0] > 5'd22);
		endcase
	end

	// Response checker: every accepted response against the oldest owed grant
	always @(posedge clk) begin : check_grant
		grant_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (grant_q.size() == 0) begin
				errors++;
				$display("%0t ns: unexpected response, expected none, got granted %0b block %0d",
					$time, rsp_ch.granted, rsp_ch.granted_block);
			end else begin
				want = grant_q.pop_front();
				if (rsp_ch.granted !== want.granted) begin
					errors++;
					$display("%0t ns: granted mismatch, expected %0b, got %0b",
						$time, want.granted, rsp_ch.granted);
				end
				if (rsp_ch.granted_block !== want.granted_block) begin
					errors++;
					$display("%0t ns: granted_block mismatch, expected %0d, got %0d",
						$time, want.granted_block, rsp_ch.granted_block);
				end
			end
		end
	end

	initial begin : stimulus
		int                        issued;
		int                        round;
		int                        round_len;
		int                        draw;
		int                        count_pick;
		logic [fpfa_pkg::OP_W-1:0] op;

		req_ch.valid       <= 1'b0;
		req_ch.op          <= fpfa_pkg::OP_LOAD;
		req_ch.block_index <= '0;
		req_ch.size        <= '0;
		cfg_ch.valid       <= 1'b0;
		cfg_ch.index       <= fpfa_pkg::REG_FIT_MODE;
		cfg_ch.data        <= '0;
		arst_n             <= 1'b0;
		foreach (blk_used[b]) begin
			blk_used[b]   = 1'b0;
			blk_loaded[b] = 1'b0;
			blk_size[b]   = '0;
		end
		fit_mode    = fpfa_pkg::MODE_FIRST;
		block_count = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int r = 0; r < SCRIPT_LEN; r++) begin
			if (SCRIPT[r].kind == ROW_CFG)
				write_reg(SCRIPT[r].code, SCRIPT[r].value[fpfa_pkg::CFG_DATA_W-1:0]);
			else
				send_request(SCRIPT[r].code, SCRIPT[r].idx, SCRIPT[r].value,
					SCRIPT[r].typed, SCRIPT[r].want);
		end

		// Random rounds: each picks a mode and a block count (full table, over-range,
		// single block, partial, any from none to full), loads any block in use that was never
		// written, then mixes loads, clears, dropped ops and allocates.
		issued = 0;
		round  = 0;
		while (issued < RANDOM_ITEMS) begin
			gaps_on = (round % 3) != 2;
			write_reg(fpfa_pkg::REG_FIT_MODE, fpfa_pkg::CFG_DATA_W'(round % 4));
			case (round % 6)
				0: count_pick = fpfa_pkg::MAX_BLOCKS;
				1: count_pick = 31;
				2: count_pick = 1;
				3: count_pick = $urandom_range(2, fpfa_pkg::MAX_BLOCKS - 1);
				4: count_pick = $urandom_range(fpfa_pkg::MAX_BLOCKS + 1, 31);
				default: count_pick = $urandom_range(0, fpfa_pkg::MAX_BLOCKS);
			endcase
			write_reg(fpfa_pkg::REG_NUM_BLOCKS, fpfa_pkg::CFG_DATA_W'(count_pick));

			// an allocate must never read a block that was never loaded
			for (int b = 0; b < active_span(); b++) begin
				if (!blk_loaded[b]) begin
					send_request(fpfa_pkg::OP_LOAD, fpfa_pkg::BIDX_W'(b), random_size(),
						1'b0, NO_GRANT);
					issued++;
				end
			end

			round_len = (block_count == 0) ? 10 : $urandom_range(40, 160);
			for (int n = 0; n < round_len && issued < RANDOM_ITEMS; n++) begin
				// once mid-round, drain the block completely before going on
				if (round == 3 && n == round_len / 2)
					hold_requests();
				draw = $urandom_range(0, 99);
				if (draw < 8)
					op = fpfa_pkg::OP_CLEAR;
				else if (draw < 35)
					op = fpfa_pkg::OP_LOAD;
				else if (draw < 39)
					op = OP_UNUSED;
				else
					op = fpfa_pkg::OP_ALLOC;
				send_request(op, fpfa_pkg::BIDX_W'($urandom_range(0, fpfa_pkg::MAX_BLOCKS - 1)),
					random_size(), 1'b0, NO_GRANT);
				issued++;
			end
			round++;
		end

		hold_requests();
		if (errors == 0)
			$display("fixed_partition_fit_allocator test passed");
		else
			$display("fixed_partition_fit_allocator test failed");
		$finish;
	end

endmodule

FILE: files.f
design/fpfa_pkg.sv
design/fpfa_req_if.sv
design/fpfa_rsp_if.sv
design/fpfa_cfg_if.sv
design/fpfa_cell.sv
design/fixed_partition_fit_allocator.sv
verif/fixed_partition_fit_allocator_test.sv
